/* sv/lzss_pkg.sv */
// Shared constants, payload types and helpers for the LZSS window decompressor.
package lzss_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int ADDR_W = $clog2(WINDOW_SIZE);
	localparam int CNT_W = 32;

	localparam logic [ADDR_W-1:0] WIN_START = ADDR_W'(12'hfee);
	localparam logic [CNT_W-1:0] LIMIT_RESET = 32'd65536;
	// Shortest match length minus one: the remaining-byte count after the first byte.
	localparam logic [4:0] MIN_MATCH_M1 = 5'd2;

	// Token phase codes.
	localparam logic [1:0] PH_FLAG = 2'd0;
	localparam logic [1:0] PH_TOKEN = 2'd1;
	localparam logic [1:0] PH_REF = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic last_in_run;
		logic stream_end;
		logic [CNT_W-1:0] total_written;
	} out_item_t;

	// Builds one result item from its fields.
	function automatic out_item_t mk_result(input logic [7:0] b, input logic bv,
			input logic last, input logic se, input logic [CNT_W-1:0] total);
		out_item_t r;
		r.out_byte = b;
		r.byte_valid = bv;
		r.last_in_run = last;
		r.stream_end = se;
		r.total_written = total;
		return r;
	endfunction

endpackage

/* sv/lzss_window_decompress_core.sv */
// LZSS decompressor core with a 4096-byte window held in a synchronous RAM.
//
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  in_item_t (in_byte, end_of_stream)
// result    out        result_valid/stall     out_item_t (byte, flags, total_written)
// cfg       in         cfg_valid/cfg_ready    output_limit, 32 bits
//
// A back reference of length L first issues the window read of its first byte, then gives
// one output byte per cycle while the result is not stalled, set by the single window RAM read port.
// Reset is asynchronous; the window is never swept: a fill count marks which
// entries belong to the current stream and the rest read as zero.
// A stalled result holds the copy sequencer in place and the read is reissued.
module lzss_window_decompress_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lzss_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output lzss_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);
	import lzss_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_COPY = 1'b1;

	// Window memory and its registered read data.
	logic [7:0] window_mem [WINDOW_SIZE];
	logic [7:0] rdata_s1;

	// Control and stream state.
	logic state_q, state_d;
	logic [CNT_W-1:0] limit_q;
	logic [ADDR_W-1:0] wp_q, wp_d;
	logic [7:0] flag_q, flag_d;
	logic [3:0] left_q, left_d, left_dec;
	logic [1:0] phase_q, phase_d;
	logic [7:0] off_q, off_d;
	logic [CNT_W-1:0] count_q, count_d, cnt_inc;
	logic lim_q, lim_d;
	logic eos_q, eos_d;
	logic [4:0] rem_q, rem_d;

	// Copy read stage.
	logic [ADDR_W-1:0] addr_s1, rd_addr, rd_ofs;
	logic fwd_s1, fwd_d;
	logic [7:0] fwd_data_s1;
	logic hit_s1, hit_d;
	logic new_read;

	// Output register.
	logic result_valid_q, rv_d;
	out_item_t result_q, res_d;

	logic out_free, accept, byte_ok, load_out, do_clear, finish, copy_start;
	logic last_len, lim_hit, last;
	logic wr_en;
	logic [7:0] wr_data, copy_data;

	assign out_free = !result_valid_q || !result_stall;
	assign item_stall = (state_q != S_IDLE) || !out_free;
	assign accept = item_valid && !item_stall;
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	assign byte_ok = count_q < limit_q;
	assign cnt_inc = count_q + 32'd1;
	assign left_dec = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
	assign copy_data = fwd_s1 ? fwd_data_s1 : (hit_s1 ? rdata_s1 : 8'd0);
	assign rd_ofs = rd_addr - WIN_START;

	// Token decoding, copy sequencing and result formation.
	always_comb begin
		state_d = state_q;
		wp_d = wp_q;
		flag_d = flag_q;
		left_d = left_q;
		phase_d = phase_q;
		off_d = off_q;
		count_d = count_q;
		lim_d = lim_q;
		eos_d = eos_q;
		rem_d = rem_q;
		rv_d = result_valid_q;
		res_d = result_q;
		wr_en = 1'b0;
		wr_data = item.in_byte;
		load_out = 1'b0;
		do_clear = 1'b0;
		finish = 1'b0;
		new_read = 1'b0;
		rd_addr = addr_s1;
		copy_start = 1'b0;
		last_len = 1'b0;
		lim_hit = 1'b0;
		last = 1'b0;

		if (accept) begin
			eos_d = item.end_of_stream;
			if (!lim_q) begin
				case (phase_q)
					PH_TOKEN: begin
						if (flag_q[0]) begin
							// Literal byte goes straight to the window and the output unless the output limit is reached.
							if (byte_ok) begin
								wr_en = 1'b1;
								load_out = 1'b1;
								res_d = mk_result(item.in_byte, 1'b1, 1'b1,
									item.end_of_stream, cnt_inc);
								count_d = cnt_inc;
								wp_d = wp_q + ADDR_W'(1);
							end else begin
								lim_d = 1'b1;
							end
							flag_d = flag_q >> 1;
							left_d = left_dec;
							phase_d = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
						end else begin
							off_d = item.in_byte;
							phase_d = PH_REF;
						end
					end
					PH_REF: begin
						// Second reference byte: issue the first window read.
						copy_start = 1'b1;
						rd_addr = {item.in_byte[7:4], off_q};
						new_read = 1'b1;
						rem_d = {1'b0, item.in_byte[3:0]} + MIN_MATCH_M1;
						state_d = S_COPY;
						flag_d = flag_q >> 1;
						left_d = left_dec;
						phase_d = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
					end
					default: begin
						flag_d = item.in_byte;
						left_d = 4'd8;
						phase_d = PH_TOKEN;
					end
				endcase
			end
			if (item.end_of_stream && !copy_start) begin
				if (!load_out) begin
					load_out = 1'b1;
					res_d = mk_result(8'd0, 1'b0, 1'b1, 1'b1, count_q);
				end
				do_clear = 1'b1;
			end
		end else if (state_q == S_COPY && out_free) begin
			// One copied byte per cycle while the result is not stalled; the limit is looked ahead to mark the last one.
			if (byte_ok) begin
				last_len = (rem_q == 5'd0);
				lim_hit = (cnt_inc == limit_q);
				last = last_len || lim_hit;
				wr_en = 1'b1;
				wr_data = copy_data;
				load_out = 1'b1;
				res_d = mk_result(copy_data, 1'b1, last, last && eos_q, cnt_inc);
				count_d = cnt_inc;
				wp_d = wp_q + ADDR_W'(1);
				if (lim_hit && !last_len) begin
					lim_d = 1'b1;
				end
				if (last) begin
					finish = 1'b1;
				end else begin
					rd_addr = addr_s1 + ADDR_W'(1);
					new_read = 1'b1;
					rem_d = rem_q - 5'd1;
				end
			end else begin
				lim_d = 1'b1;
				finish = 1'b1;
			end
			if (finish) begin
				state_d = S_IDLE;
				if (eos_q) begin
					if (!load_out) begin
						load_out = 1'b1;
						res_d = mk_result(8'd0, 1'b0, 1'b1, 1'b1, count_q);
					end
					do_clear = 1'b1;
				end
			end
		end

		// Output register valid tracking.
		if (load_out) begin
			rv_d = 1'b1;
		end else if (result_valid_q && !result_stall) begin
			rv_d = 1'b0;
		end

		// New stream: the fill count returning to zero empties the window.
		if (do_clear) begin
			wp_d = WIN_START;
			flag_d = 8'd0;
			left_d = 4'd0;
			phase_d = PH_FLAG;
			off_d = 8'd0;
			count_d = '0;
			lim_d = 1'b0;
		end
	end

	// Forwarding of a same-cycle write and the fill-count check of the new read.
	always_comb begin
		fwd_d = 1'b0;
		hit_d = hit_s1;
		if (new_read) begin
			fwd_d = wr_en && (rd_addr == wp_q);
			hit_d = (count_q[CNT_W-1:ADDR_W] != '0) ||
				({1'b0, rd_ofs} < ({1'b0, count_q[ADDR_W-1:0]} + {{ADDR_W{1'b0}}, wr_en}));
		end
	end

	// Window RAM: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			window_mem[wp_q] <= wr_data;
		end
		rdata_s1 <= window_mem[rd_addr];
	end

	// Read stage payload registers and the output payload register.
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		fwd_data_s1 <= wr_data;
		result_q <= res_d;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= LIMIT_RESET;
			wp_q <= WIN_START;
			flag_q <= 8'd0;
			left_q <= 4'd0;
			phase_q <= PH_FLAG;
			off_q <= 8'd0;
			count_q <= '0;
			lim_q <= 1'b0;
			eos_q <= 1'b0;
			rem_q <= 5'd0;
			fwd_s1 <= 1'b0;
			hit_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			wp_q <= wp_d;
			flag_q <= flag_d;
			left_q <= left_d;
			phase_q <= phase_d;
			off_q <= off_d;
			count_q <= count_d;
			lim_q <= lim_d;
			eos_q <= eos_d;
			rem_q <= rem_d;
			fwd_s1 <= fwd_d;
			hit_s1 <= hit_d;
			result_valid_q <= rv_d;
		end
	end

`ifndef SYNTHESIS
	// Every window write shows up as a data result in the next cycle.
	a_write_shows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (result_valid && result.byte_valid))
		else $error("window write without a data result");

	// The end of a stream always closes the run of its input.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.stream_end) |-> result.last_in_run)
		else $error("stream end result not marked last");

	// A data result counts at least one produced byte.
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.byte_valid) |-> (result.total_written != '0))
		else $error("data result with zero total");

	// No stream end is pending while a copy is still running.
	a_copy_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> !(result_valid && result.stream_end))
		else $error("stream end seen during a copy");
`endif

endmodule

/* tb/sv/tb_lzss_window_decompress_core.sv */
// Self-checking testbench for the LZSS window decompressor core with a built-in decoder model.
module tb_lzss_window_decompress_core;
	import lzss_pkg::*;

	localparam int ITEM_TARGET = 400;
	localparam int PHASE_ITEMS = 60;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	// Decoder model state, kept in step with every accepted input transaction.
	logic [7:0] dec_window [WINDOW_SIZE];
	logic [ADDR_W-1:0] dec_wpos;
	logic [7:0] dec_flags;
	logic [3:0] dec_left;
	logic [1:0] dec_phase;
	logic [7:0] dec_offlo;
	logic [CNT_W-1:0] dec_count;
	logic dec_stop;
	logic [CNT_W-1:0] dec_limit = LIMIT_RESET;

	out_item_t step_out[$];
	out_item_t bytes_due[$];
	in_item_t comp_bytes[$];
	out_item_t want;

	int n_live = 0;
	int n_fail = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int gap_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	lzss_window_decompress_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Start of a new stream: empty window and token parser back at the flag byte.
	function automatic void clear_decoder();
		foreach (dec_window[i]) dec_window[i] = '0;
		dec_wpos = WIN_START;
		dec_flags = '0;
		dec_left = '0;
		dec_phase = PH_FLAG;
		dec_offlo = '0;
		dec_count = '0;
		dec_stop = 1'b0;
	endfunction

	// One decoded byte goes to the output and into the window, unless the limit stops it.
	function automatic void emit_byte(input logic [7:0] b);
		out_item_t r;
		if (dec_stop)
			return;
		if (dec_count >= dec_limit) begin
			dec_stop = 1'b1;
			return;
		end
		dec_window[dec_wpos] = b;
		dec_wpos = dec_wpos + 1'b1;
		dec_count = dec_count + 1'b1;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		r.last_in_run = 1'b0;
		r.stream_end = 1'b0;
		r.total_written = dec_count;
		step_out.push_back(r);
	endfunction

	function automatic void next_token();
		dec_flags = dec_flags >> 1;
		if (dec_left != 0)
			dec_left = dec_left - 1'b1;
		dec_phase = (dec_left != 0) ? PH_TOKEN : PH_FLAG;
	endfunction

	// Works out the results caused by one compressed byte and queues them.
	function automatic void decode_input(input in_item_t it);
		out_item_t r;
		logic [ADDR_W-1:0] pos;
		logic [ADDR_W-1:0] rd;
		int len;
		step_out.delete();
		n_live++;
		if (!dec_stop) begin
			case (dec_phase)
				PH_TOKEN: begin
					if (dec_flags[0]) begin
						emit_byte(it.in_byte);
						next_token();
					end else begin
						dec_offlo = it.in_byte;
						dec_phase = PH_REF;
					end
				end
				PH_REF: begin
					pos = {it.in_byte[7:4], dec_offlo};
					len = int'(it.in_byte[3:0]) + 3;
					// Byte-by-byte copy so that an overlapping copy sees its own output.
					for (int i = 0; i < len && !dec_stop; i++) begin
						rd = pos + ADDR_W'(i);
						emit_byte(dec_window[rd]);
					end
					next_token();
				end
				default: begin
					dec_flags = it.in_byte;
					dec_left = 4'd8;
					dec_phase = PH_TOKEN;
				end
			endcase
		end
		// An end of stream with no data gets an end-only marker.
		if (it.end_of_stream && step_out.size() == 0) begin
			r = '0;
			r.total_written = dec_count;
			step_out.push_back(r);
		end
		if (step_out.size() > 0) begin
			r = step_out.pop_back();
			r.last_in_run = 1'b1;
			r.stream_end = it.end_of_stream;
			step_out.push_back(r);
		end
		foreach (step_out[i]) bytes_due.push_back(step_out[i]);
		if (it.end_of_stream)
			clear_decoder();
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		in_item_t x;
		x.in_byte = b;
		x.end_of_stream = 1'b0;
		comp_bytes.push_back(x);
	endfunction

	function automatic void end_stream();
		in_item_t x;
		x = comp_bytes.pop_back();
		x.end_of_stream = 1'b1;
		comp_bytes.push_back(x);
	endfunction

	// Well-formed stream with random tokens; back references mostly point at recent output.
	function automatic void gen_stream();
		logic [7:0] flags;
		logic [ADDR_W-1:0] pos;
		logic [ADDR_W-1:0] gen_wpos;
		logic [3:0] lm3;
		int left;
		int n_tok;
		int back;
		int gen_count;
		flags = '0;
		left = 0;
		gen_wpos = WIN_START;
		gen_count = 0;
		n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 25);
		for (int t = 0; t < n_tok; t++) begin
			if (left == 0) begin
				flags = 8'($urandom);
				push_byte(flags);
				left = 8;
			end
			if (flags[0]) begin
				push_byte(8'($urandom));
				gen_wpos = gen_wpos + 1'b1;
				gen_count++;
			end else begin
				lm3 = 4'($urandom);
				if (gen_count == 0 || $urandom_range(0, 5) == 0) begin
					pos = ADDR_W'($urandom);
				end else begin
					back = $urandom_range(1, (gen_count < 300) ? gen_count : 300);
					pos = gen_wpos - ADDR_W'(back);
				end
				push_byte(pos[7:0]);
				push_byte({pos[11:8], lm3});
				gen_wpos = gen_wpos + ADDR_W'(int'(lm3) + 3);
				gen_count += int'(lm3) + 3;
			end
			flags = flags >> 1;
			left--;
		end
		// Now and then the stream ends inside a token: a lone flag byte or half a reference.
		if ($urandom_range(0, 3) == 0) begin
			if (left == 0 || !flags[0])
				push_byte(8'($urandom));
		end
		end_stream();
	endfunction

	// Stream of raw random bytes.
	function automatic void gen_noise();
		int n;
		n = $urandom_range(1, 20);
		repeat (n) push_byte(8'($urandom));
		end_stream();
	endfunction

	task automatic set_limit(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		dec_limit = v;
		cfg_valid <= 1'b0;
	endtask

	// Waits until every byte is sent and every result has arrived, then lets the core settle.
	task automatic wait_drained();
		do @(negedge clk); while (comp_bytes.size() != 0 || item_valid || bytes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: sends queued compressed bytes, with random gaps between transactions.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				decode_input(item);
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (comp_bytes.size() > 0 && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
					gap_left = $urandom_range(0, 6);
					item_valid <= 1'b0;
				end else if (comp_bytes.size() > 0) begin
					item <= comp_bytes.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result transaction and applies random stall bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (bytes_due.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected result: byte %02h valid %0b last %0b end %0b total %0d",
							result.out_byte, result.byte_valid, result.last_in_run,
							result.stream_end, result.total_written);
				end else begin
					want = bytes_due.pop_front();
					if (result.out_byte !== want.out_byte || result.byte_valid !== want.byte_valid ||
							result.last_in_run !== want.last_in_run ||
							result.stream_end !== want.stream_end ||
							result.total_written !== want.total_written) begin
						n_fail++;
						if (n_fail <= 10)
							$display({"mismatch: want byte %02h valid %0b last %0b end %0b total %0d,",
								" got byte %02h valid %0b last %0b end %0b total %0d"},
								want.out_byte, want.byte_valid, want.last_in_run,
								want.stream_end, want.total_written,
								result.out_byte, result.byte_valid, result.last_in_run,
								result.stream_end, result.total_written);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 6);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: counts busy cycles in which no transaction completes on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready) ||
					(comp_bytes.size() == 0 && !item_valid && bytes_due.size() == 0 && !cfg_valid))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Test sequence: directed streams first, then random phases under several limits, then a closing stretch.
	initial begin
		logic [31:0] lim;
		int phase;
		clear_decoder();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_limit(32'hffff_ffff);
		@(negedge clk);
		// Literal 0xff, overlapping 18-byte copy of it, copy from position zero, literal at the end.
		push_byte(8'h09);
		push_byte(8'hff);
		push_byte(8'hee);
		push_byte(8'hff);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'h00);
		end_stream();
		// A flag byte with nothing after it.
		push_byte(8'h00);
		end_stream();
		// A back reference cut off after its first byte.
		push_byte(8'h00);
		push_byte(8'h12);
		end_stream();
		wait_drained();

		// Copy cut short by the limit, then the rest of the stream is ignored.
		set_limit(32'd5);
		@(negedge clk);
		push_byte(8'h03);
		push_byte(8'h41);
		push_byte(8'h42);
		push_byte(8'hee);
		push_byte(8'hff);
		push_byte(8'h55);
		push_byte(8'haa);
		end_stream();
		wait_drained();

		// Zero limit: the first literal already stops the stream.
		set_limit(32'd0);
		@(negedge clk);
		push_byte(8'hff);
		push_byte(8'h77);
		end_stream();
		wait_drained();

		// Limit raised in the middle of a stream.
		set_limit(32'd2);
		@(negedge clk);
		push_byte(8'hff);
		push_byte(8'h01);
		push_byte(8'h02);
		wait_drained();
		set_limit(32'hffff_ffff);
		@(negedge clk);
		push_byte(8'h03);
		end_stream();
		wait_drained();

		// Random phases; each one drains completely before the limit changes.
		phase = 0;
		while (n_live < ITEM_TARGET) begin
			case (phase % 5)
				0: lim = LIMIT_RESET;
				1: lim = 32'hffff_ffff;
				2: lim = $urandom_range(20, 300);
				3: lim = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 19);
				default: lim = $urandom;
			endcase
			set_limit(lim);
			@(negedge clk);
			gap_pct = (phase % 3 == 2) ? 0 : $urandom_range(10, 50);
			stall_pct = (phase % 4 == 3) ? 0 : $urandom_range(10, 50);
			while (comp_bytes.size() < PHASE_ITEMS) begin
				if ($urandom_range(0, 7) == 0)
					gen_noise();
				else
					gen_stream();
			end
			wait_drained();
			phase++;
		end

		// Closing stretch at full rate on both sides.
		gap_pct = 0;
		stall_pct = 0;
		set_limit(32'hffff_ffff);
		@(negedge clk);
		while (comp_bytes.size() < 40)
			gen_stream();
		wait_drained();

		if (n_fail == 0 && bytes_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
